### rtl/core/me_pkg.sv
// Package for the modular exponentiation block: widths, request/result types.
package me_pkg;

    localparam int WIDTH  = 31;
    localparam int EXP_W  = 32;
    localparam int CNT_W  = $clog2(WIDTH + 1);

    typedef struct packed {
        logic [WIDTH-1:0]        base;
        logic signed [EXP_W-1:0] exponent;
        logic [WIDTH-1:0]        modulus;
    } t_me_in;

    typedef struct packed {
        logic [WIDTH-1:0] power;
        logic             error;
    } t_me_out;

endpackage

### rtl/core/me_modmul.sv
// Bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle.
module me_modmul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [me_pkg::WIDTH-1:0] i_a,
    input  logic [me_pkg::WIDTH-1:0] i_b,
    input  logic [me_pkg::WIDTH-1:0] i_m,
    output logic                     o_done,
    output logic [me_pkg::WIDTH-1:0] o_r
);
    import me_pkg::*;

    logic [WIDTH-1:0] r_r, n_r;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_m;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0] dbl, dbl_red, sum, sum_red;

    // Double the remainder, reduce, add a when the bit of b is set, reduce
    always_comb begin
        dbl     = {r_r, 1'b0};
        dbl_red = (dbl >= {1'b0, r_m}) ? dbl - {1'b0, r_m} : dbl;
        sum     = dbl_red + {1'b0, r_a};
        if (!r_b[WIDTH-1]) begin
            sum_red = dbl_red;
        end else if (sum >= {1'b0, r_m}) begin
            sum_red = sum - {1'b0, r_m};
        end else begin
            sum_red = sum;
        end
        n_r = sum_red[WIDTH-1:0];
    end

    // Control: count WIDTH steps per product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Datapath: latch operands, then shift b out MSB first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r <= '0;
            r_a <= i_a;
            r_b <= i_b;
            r_m <= i_m;
        end else if (r_busy) begin
            r_r <= n_r;
            r_b <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_r    = r_r;

endmodule

### rtl/core/modular_exponentiation.sv
// Modular exponentiation top level: request sequencer around a serial multiplier.
//
// Usage: a request (base, signed exponent, modulus) enters on the input
// valid/ready channel; one result (power, error) leaves on the output
// valid/ready channel for every request.
// Exponent one returns the base unreduced, exponent zero returns one, a
// negative exponent returns zero with error set, and a zero modulus with a
// larger exponent returns zero. These skip the multiplier.
// Otherwise the exponent is scanned from its low bit, right-to-left
// square-and-multiply. Each modular product runs through one shared
// bit-serial multiplier. One product reduces the base, each exponent bit
// above the lowest costs a square, and each set bit costs a multiply.
// One request is worked at a time; the next one is accepted once the
// sequencer is idle, even while the previous result waits in the output
// register. If the receiver stalls, the finished result holds in the
// sequencer until the output register frees.
// Reset (synchronous, active low) drops any request in progress and
// empties the output register.
module modular_exponentiation (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  me_pkg::t_me_in i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output me_pkg::t_me_out o_out
);
    import me_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]       r_state;
    logic             r_go;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_sq;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_mod;
    logic [EXP_W-2:0] r_e;
    logic             r_err;
    logic             r_out_valid;
    t_me_out          r_out;

    logic             accept;
    logic             out_load;
    logic             mm_done;
    logic [WIDTH-1:0] mm_res;
    logic [WIDTH-1:0] mm_a, mm_b;
    logic [EXP_W-2:0] e_shr;

    assign accept   = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign e_shr    = r_e >> 1;

    // Select multiplier operands by phase
    always_comb begin
        unique case (r_state)
            S_RED: begin
                mm_a = r_acc;
                mm_b = r_base;
            end
            S_ACC: begin
                mm_a = r_acc;
                mm_b = r_sq;
            end
            default: begin
                mm_a = r_sq;
                mm_b = r_sq;
            end
        endcase
    end

    me_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_a     (mm_a),
        .i_b     (mm_b),
        .i_m     (r_mod),
        .o_done  (mm_done),
        .o_r     (mm_res)
    );

    // Sequencer: special cases, reduction, square-and-multiply loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state) inside
                S_IDLE: begin
                    if (accept) begin
                        if (i_in.exponent == EXP_W'(1)) begin
                            r_state <= S_DONE;
                        end else if (i_in.exponent == '0) begin
                            r_state <= S_DONE;
                        end else if (i_in.exponent[EXP_W-1]) begin
                            r_state <= S_DONE;
                        end else if (i_in.modulus == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_RED;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_RED, S_SQR: begin
                    if (mm_done) begin
                        r_go <= 1'b1;
                        if (r_e[0]) begin
                            r_state <= S_ACC;
                        end else begin
                            r_state <= S_SQR;
                        end
                    end
                end
                S_ACC: begin
                    if (mm_done) begin
                        if (e_shr == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SQR;
                            r_go    <= 1'b1;
                        end
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Working registers: hold the request and the running products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_base <= i_in.base;
            r_mod  <= i_in.modulus;
            r_e    <= i_in.exponent[EXP_W-2:0];
            r_err  <= 1'b0;
            if (i_in.exponent == EXP_W'(1)) begin
                r_acc <= i_in.base;
            end else if (i_in.exponent == '0) begin
                r_acc <= WIDTH'(1);
            end else if (i_in.exponent[EXP_W-1]) begin
                r_acc <= '0;
                r_err <= 1'b1;
            end else if (i_in.modulus == '0) begin
                r_acc <= '0;
            end else if (i_in.modulus == WIDTH'(1)) begin
                r_acc <= '0;
            end else begin
                r_acc <= WIDTH'(1);
            end
        end else if (mm_done) begin
            case (r_state)
                S_RED: begin
                    r_sq <= mm_res;
                    if (!r_e[0]) begin
                        r_e <= e_shr;
                    end
                end
                S_SQR: begin
                    r_sq <= mm_res;
                    if (!r_e[0]) begin
                        r_e <= e_shr;
                    end
                end
                S_ACC: begin
                    r_acc <= mm_res;
                    r_e   <= e_shr;
                end
                default: begin
                    r_e <= r_e;
                end
            endcase
        end
    end

    // Output register: load the result, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.power <= r_acc;
            r_out.error <= r_err;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### tb/testbench.sv
// Testbench for the modular exponentiation block: directed and random requests against a predictor.
`timescale 1ns / 100ps

module testbench;
    import me_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int TIMEOUT_NS   = 36_000_000;
    localparam int RANDOM_COUNT = 270;
    localparam int QUIET_TAIL   = 40;
    localparam int LONG_HOLD    = 5000;
    localparam int SETTLE       = 60;

    localparam logic [WIDTH-1:0] VAL_MAX = {WIDTH{1'b1}};

    // Holds the expected results in request order and checks each result.
    class power_scoreboard;
        t_me_out     expected_q[$];
        int unsigned errors;

        // Right-to-left square-and-multiply with exact 64-bit products.
        function t_me_out predict_power(t_me_in req);
            logic [63:0] modv;
            logic [63:0] acc;
            logic [63:0] sq;
            logic [31:0] expv;
            t_me_out     res;
            modv      = 64'(req.modulus);
            expv      = req.exponent;
            res.power = '0;
            res.error = 1'b0;
            if (expv == 32'd1) begin
                res.power = req.base;
            end else if (expv == 32'd0) begin
                res.power = WIDTH'(1);
            end else if (expv[31]) begin
                res.error = 1'b1;
            end else if (modv != 64'd0) begin
                sq  = 64'(req.base) % modv;
                acc = 64'd1 % modv;
                while (expv != 32'd0) begin
                    if (expv[0]) begin
                        acc = (acc * sq) % modv;
                    end
                    expv = expv >> 1;
                    sq   = (sq * sq) % modv;
                end
                res.power = acc[WIDTH-1:0];
            end
            return res;
        endfunction

        function void note_request(t_me_in req);
            expected_q.push_back(predict_power(req));
        endfunction

        function void check_result(t_me_out got);
            t_me_out want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual power %h error %b",
                         $time, got.power, got.error);
                return;
            end
            want = expected_q.pop_front();
            if (got.power !== want.power) begin
                errors++;
                $display("%0t: power mismatch, expected %h, actual %h",
                         $time, want.power, got.power);
            end
            if (got.error !== want.error) begin
                errors++;
                $display("%0t: error flag mismatch, expected %b, actual %b",
                         $time, want.error, got.error);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    i_in_valid;
    logic    o_in_ready;
    t_me_in  i_in;
    logic    o_out_valid;
    logic    i_out_ready;
    t_me_out o_out;

    power_scoreboard sb = new();

    bit tx_bursts_on;
    bit rx_bursts_on;
    bit rx_long_hold;

    modular_exponentiation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // Generate the clock.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // End the run if it hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Observe both handshakes at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                sb.note_request(i_in);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out);
            end
        end
    end

    // Drive result ready: random stall bursts, plus one long hold on request.
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            if (rx_long_hold) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                rx_long_hold = 1'b0;
            end else if (rx_bursts_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic t_me_in make_req(logic [WIDTH-1:0] base, logic [31:0] expv,
                                        logic [WIDTH-1:0] modv);
        t_me_in req;
        req.base     = base;
        req.exponent = expv;
        req.modulus  = modv;
        return req;
    endfunction

    // Offer one request and hold it until accepted; with sender bursts on, valid may then drop for a random gap.
    task automatic send_request(input t_me_in req);
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (!o_in_ready);
        if (tx_bursts_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every expected result.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random request: mostly short exponents, a few full length, some zero, one or negative.
    function automatic t_me_in random_req();
        int unsigned      sel;
        int unsigned      nbits;
        logic [31:0]      expv;
        logic [WIDTH-1:0] base;
        logic [WIDTH-1:0] modv;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            expv = 32'($urandom_range(0, 1));
        end else if (sel < 15) begin
            expv = {1'b1, 31'($urandom)};
        end else begin
            nbits = ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(2, 12);
            expv  = ($urandom & ((32'd1 << nbits) - 1)) | (32'd1 << (nbits - 1));
        end
        case ($urandom_range(0, 5))
            0:       base = WIDTH'($urandom_range(0, 20));
            1:       base = VAL_MAX - WIDTH'($urandom_range(0, 3));
            default: base = WIDTH'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       modv = WIDTH'($urandom_range(1, 3));
            1:       modv = WIDTH'($urandom_range(1, 1000));
            2:       modv = VAL_MAX - WIDTH'($urandom_range(0, 3));
            default: modv = WIDTH'($urandom);
        endcase
        if (modv == '0) begin
            modv = WIDTH'(1);
        end
        return make_req(base, expv, modv);
    endfunction

    // Main sequence: reset, directed requests, random requests, drain.
    initial begin
        t_me_in directed_q[$];

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_in         <= '0;
        tx_bursts_on = 1'b1;
        rx_bursts_on = 1'b1;
        rx_long_hold = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Exponent zero and one pass through without reduction.
        directed_q.push_back(make_req('0, 32'd0, WIDTH'(1)));
        directed_q.push_back(make_req(VAL_MAX, 32'd0, WIDTH'(1)));
        directed_q.push_back(make_req(VAL_MAX, 32'd1, WIDTH'(1)));
        directed_q.push_back(make_req('0, 32'd1, VAL_MAX));
        directed_q.push_back(make_req(WIDTH'(77), 32'd0, '0));
        directed_q.push_back(make_req(WIDTH'(77), 32'd1, '0));
        // Negative exponents raise the error flag.
        directed_q.push_back(make_req(WIDTH'(5), 32'hFFFF_FFFF, WIDTH'(7)));
        directed_q.push_back(make_req(VAL_MAX, 32'h8000_0000, VAL_MAX));
        // Zero modulus with a larger exponent gives zero.
        directed_q.push_back(make_req(WIDTH'(9), 32'd2, '0));
        directed_q.push_back(make_req(VAL_MAX, 32'd5, '0));
        // Modulus one, and base equal to, above and below the modulus.
        directed_q.push_back(make_req(WIDTH'(12345), 32'd2, WIDTH'(1)));
        directed_q.push_back(make_req(VAL_MAX, 32'd2, VAL_MAX));
        directed_q.push_back(make_req(WIDTH'(100), 32'd3, WIDTH'(7)));
        directed_q.push_back(make_req(VAL_MAX, 32'd3, VAL_MAX - WIDTH'(1)));
        directed_q.push_back(make_req('0, 32'd2, WIDTH'(13)));
        directed_q.push_back(make_req(WIDTH'(3), 32'd5, WIDTH'(7)));
        directed_q.push_back(make_req(WIDTH'(2), 32'd30, VAL_MAX));
        // Largest operands and full-length exponent.
        directed_q.push_back(make_req(VAL_MAX - WIDTH'(1), 32'h7FFF_FFFF, VAL_MAX));
        directed_q.push_back(make_req(VAL_MAX, 32'h5555_5555, VAL_MAX - WIDTH'(2)));
        directed_q.push_back(make_req(WIDTH'(31'h2AAA_AAAA), 32'h2AAA_AAAA, WIDTH'(31'h5555_5555)));
        foreach (directed_q[k]) begin
            send_request(directed_q[k]);
        end

        // Pause the sender until everything has come back.
        wait_drained();

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n >= RANDOM_COUNT - QUIET_TAIL) begin
                tx_bursts_on = 1'b0;
                rx_bursts_on = 1'b0;
            end else begin
                tx_bursts_on = ((n / 30) % 3) != 2;
                rx_bursts_on = ((n / 25) % 3) != 1;
            end
            if (n == 60) begin
                rx_long_hold = 1'b1;
            end
            send_request(random_req());
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
